// ----- hdl/tdrd_pkg.sv -----
// shared types and constants of the tls/dtls record deframer
package tdrd_pkg;

   // default count of usable fragment length bits
   localparam int LengthBitsDefault = 14;

   // width of the reported fragment length field
   localparam int FragBits = 14;

   // byte address width of the register port
   localparam int CsrAddrBits = 5;

   // status codes of a result word
   localparam logic [2:0] StOk        = 3'd0;
   localparam logic [2:0] StBadType   = 3'd1;
   localparam logic [2:0] StBadVer    = 3'd2;
   localparam logic [2:0] StBadLength = 3'd3;
   localparam logic [2:0] StTooSmall  = 3'd4;

   // input word: one stream byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_word_type;

   // result word: one per stream byte
   typedef struct packed {
      logic [7:0]          payload_byte;
      logic                payload_valid;
      logic                header_done;
      logic [7:0]          content_type;
      logic [15:0]         protocol_version;
      logic                is_datagram;
      logic [15:0]         epoch;
      logic [47:0]         sequence_number;
      logic [FragBits-1:0] fragment_length;
      logic [2:0]          status;
      logic                record_end;
   } rsp_word_type;

   // check limits from the register file
   typedef struct packed {
      logic [7:0]  type_lowest;
      logic [7:0]  type_highest;
      logic [15:0] stream_ver_lowest;
      logic [15:0] stream_ver_highest;
      logic [15:0] dgram_ver_newest;
      logic [15:0] dgram_ver_oldest;
   } cfg_type;

endpackage

// ----- hdl/tdrd_csr.sv -----
// register file holding the content type and version limits
module tdrd_csr
   import tdrd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   // register indexes
   localparam logic [2:0] RegTypeLo   = 3'd0;
   localparam logic [2:0] RegTypeHi   = 3'd1;
   localparam logic [2:0] RegStreamLo = 3'd2;
   localparam logic [2:0] RegStreamHi = 3'd3;
   localparam logic [2:0] RegDgramNew = 3'd4;
   localparam logic [2:0] RegDgramOld = 3'd5;

   cfg_type    cfg_ff;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_lowest        <= 8'd20;
         cfg_ff.type_highest       <= 8'd23;
         cfg_ff.stream_ver_lowest  <= 16'h0301;
         cfg_ff.stream_ver_highest <= 16'h0304;
         cfg_ff.dgram_ver_newest   <= 16'hFEFC;
         cfg_ff.dgram_ver_oldest   <= 16'hFEFF;
      end else if (wr_en) begin
         case (reg_index)
            RegTypeLo:   cfg_ff.type_lowest        <= pwdata[7:0];
            RegTypeHi:   cfg_ff.type_highest       <= pwdata[7:0];
            RegStreamLo: cfg_ff.stream_ver_lowest  <= pwdata[15:0];
            RegStreamHi: cfg_ff.stream_ver_highest <= pwdata[15:0];
            RegDgramNew: cfg_ff.dgram_ver_newest   <= pwdata[15:0];
            RegDgramOld: cfg_ff.dgram_ver_oldest   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_index)
         RegTypeLo:   prdata = {24'd0, cfg_ff.type_lowest};
         RegTypeHi:   prdata = {24'd0, cfg_ff.type_highest};
         RegStreamLo: prdata = {16'd0, cfg_ff.stream_ver_lowest};
         RegStreamHi: prdata = {16'd0, cfg_ff.stream_ver_highest};
         RegDgramNew: prdata = {16'd0, cfg_ff.dgram_ver_newest};
         RegDgramOld: prdata = {16'd0, cfg_ff.dgram_ver_oldest};
         default:     prdata = 32'd0;
      endcase
   end

endmodule

// ----- hdl/tdrd_parse.sv -----
// record header state machine and per-byte result logic
module tdrd_parse
   import tdrd_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  req_word_type req,
   input  cfg_type      cfg,
   output rsp_word_type res
);

   // record phases
   localparam logic [1:0] PhHeader  = 2'd0;
   localparam logic [1:0] PhPayload = 2'd1;
   localparam logic [1:0] PhSkip    = 2'd2;

   // length bits that must be clear
   localparam logic [15:0] LenForbid = 16'hFFFF << LENGTH_BITS;
   localparam logic [7:0]  DtlsMarker = 8'hFE;

   logic [1:0]             phase_ff, phase_in;
   logic [3:0]             count_ff, count_in;
   logic [7:0]             type_ff, type_in;
   logic [15:0]            version_ff, version_in;
   logic [15:0]            epoch_ff, epoch_in;
   logic [47:0]            seq_ff, seq_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [7:0]             len_high_ff, len_high_in;

   logic [7:0]             b;
   logic                   last;
   logic [15:0]            word;
   logic [LENGTH_BITS-1:0] len_keep;
   logic                   len_bad;
   logic                   dtls;
   logic                   type_bad;
   logic                   stream_bad;
   logic                   dgram_bad;
   logic                   finish;
   logic                   stop;
   logic                   fail;
   logic [2:0]             fail_code;

   assign b        = req.data_byte;
   assign last     = req.buffer_end;
   assign word     = {len_high_ff, b};
   assign len_keep = word[LENGTH_BITS-1:0];
   assign len_bad  = (word & LenForbid) != 16'd0;
   assign dtls     = version_ff[15:8] == DtlsMarker;
   assign type_bad = (type_ff < cfg.type_lowest) || (type_ff > cfg.type_highest);
   assign stream_bad = (version_ff < cfg.stream_ver_lowest) ||
                       (version_ff > cfg.stream_ver_highest);
   assign dgram_bad  = (version_ff > cfg.dgram_ver_oldest) ||
                       (version_ff < cfg.dgram_ver_newest);

   // next state and result for the byte at the input
   always_comb begin
      res         = '0;
      phase_in    = phase_ff;
      count_in    = count_ff;
      type_in     = type_ff;
      version_in  = version_ff;
      epoch_in    = epoch_ff;
      seq_in      = seq_ff;
      length_in   = length_ff;
      left_in     = left_ff;
      len_high_in = len_high_ff;
      finish      = 1'b0;
      stop        = 1'b0;
      fail        = 1'b0;
      fail_code   = StOk;
      case (phase_ff)
         PhPayload: begin
            res.payload_byte     = b;
            res.payload_valid    = 1'b1;
            res.content_type     = type_ff;
            res.protocol_version = version_ff;
            res.is_datagram      = dtls;
            res.epoch            = epoch_ff;
            res.sequence_number  = seq_ff;
            res.fragment_length  = length_ff[FragBits-1:0];
            if (left_ff <= LENGTH_BITS'(1)) begin
               res.record_end = 1'b1;
               left_in        = '0;
               phase_in       = PhHeader;
               count_in       = 4'd0;
            end else begin
               left_in = left_ff - LENGTH_BITS'(1);
               if (last) begin
                  res.status = StTooSmall;
                  phase_in   = PhHeader;
                  count_in   = 4'd0;
               end
            end
         end
         PhHeader: begin
            count_in = count_ff + 4'd1;
            case (count_ff)
               4'd0: begin
                  type_in    = b;
                  version_in = '0;
                  epoch_in   = '0;
                  seq_in     = '0;
                  length_in  = '0;
               end
               4'd1: version_in = {b, 8'h00};
               4'd2: version_in = {version_ff[15:8], b};
               4'd3, 4'd11: len_high_in = b;
               4'd4: begin
                  if (type_bad) begin
                     fail      = 1'b1;
                     fail_code = StBadType;
                  end else if (dtls) begin
                     if (dgram_bad) begin
                        fail      = 1'b1;
                        fail_code = StBadVer;
                     end else begin
                        epoch_in = word;
                     end
                  end else if (stream_bad) begin
                     fail      = 1'b1;
                     fail_code = StBadVer;
                  end else begin
                     finish = 1'b1;
                  end
               end
               4'd12: finish = 1'b1;
               4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: seq_in = {seq_ff[39:0], b};
               default: ;
            endcase
            // header complete: length check and hand-off to payload
            if (finish) begin
               if (len_bad) begin
                  fail      = 1'b1;
                  fail_code = StBadLength;
               end else begin
                  stop      = 1'b1;
                  length_in = len_keep;
                  if (len_keep == '0 || !last) begin
                     res.header_done      = 1'b1;
                     res.content_type     = type_ff;
                     res.protocol_version = version_ff;
                     res.is_datagram      = dtls;
                     res.epoch            = epoch_ff;
                     res.sequence_number  = seq_ff;
                     res.fragment_length  = len_keep[FragBits-1:0];
                  end
                  if (len_keep == '0) begin
                     res.record_end = 1'b1;
                     phase_in       = PhHeader;
                     count_in       = 4'd0;
                  end else if (last) begin
                     res.status = StTooSmall;
                     phase_in   = PhHeader;
                     count_in   = 4'd0;
                  end else begin
                     phase_in = PhPayload;
                     left_in  = len_keep;
                  end
               end
            end
            // bad or cut-short header: report, skip to buffer end
            if (fail) begin
               res.status = fail_code;
               count_in   = 4'd0;
               phase_in   = last ? PhHeader : PhSkip;
            end else if (!stop && last) begin
               res.status = StTooSmall;
               phase_in   = PhHeader;
               count_in   = 4'd0;
            end
         end
         default: begin
            if (last) begin
               phase_in = PhHeader;
               count_in = 4'd0;
            end
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhHeader;
         count_ff    <= 4'd0;
         type_ff     <= '0;
         version_ff  <= '0;
         epoch_ff    <= '0;
         seq_ff      <= '0;
         length_ff   <= '0;
         left_ff     <= '0;
         len_high_ff <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         type_ff     <= type_in;
         version_ff  <= version_in;
         epoch_ff    <= epoch_in;
         seq_ff      <= seq_in;
         length_ff   <= length_in;
         left_ff     <= left_in;
         len_high_ff <= len_high_in;
      end
   end

`ifndef SYNTHESIS
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhPayload |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhHeader |-> count_ff <= 4'd12)
      else $error("header byte count past dtls header");

   a_enter_payload: assert property (@(posedge clock) disable iff (reset)
      take && res.header_done && !res.record_end |=> phase_ff == PhPayload)
      else $error("valid header did not start payload");

   a_enter_skip: assert property (@(posedge clock) disable iff (reset)
      take && res.status != StOk && res.status != StTooSmall && !req.buffer_end
      |=> phase_ff == PhSkip)
      else $error("header error did not start skipping");
`endif

endmodule

// ----- hdl/tdrd_outreg.sv -----
// result register between the parser and the result channel
module tdrd_outreg
   import tdrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  rsp_word_type res,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_word_type rsp_data,
   output logic         busy
);

   logic         valid_ff;
   rsp_word_type data_ff;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   // full and held: the input side must wait
   assign busy      = valid_ff & rsp_stall;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= res;
      end
   end

endmodule

// ----- hdl/tls_dtls_record_deframer.sv -----
// top level of the tls/dtls record deframer
//
//   channel  ports                          moves
//   req      req_valid/req_stall/req_data   one stream byte per word
//   rsp      rsp_valid/rsp_stall/rsp_data   one result word per stream byte
//   csr      psel/penable/pwrite/paddr/...  six limit registers, 4-byte spaced
//
// one word per cycle: each byte is decoded by the header state machine in the
// cycle it is taken and its result lands in the output register on that edge
// a byte is taken while the output register is empty or being drained
// rsp_stall with a full output register raises req_stall in the same cycle
// reset is synchronous and restores the default limits and header collection
module tls_dtls_record_deframer
   import tdrd_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   cfg_type      cfg;
   rsp_word_type res;
   logic         take;
   logic         busy;

   assign req_stall = busy;
   assign take      = req_valid & ~busy;

   // limit registers
   tdrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // header parser
   tdrd_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .cfg   (cfg),
      .res   (res)
   );

   // result register
   tdrd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (busy)
   );

endmodule
